// ----- hw/rtl/cdt_pkg.sv -----
// shared types and constants for the character display terminal
package cdt_pkg;

  localparam int SCREEN_COLS_DEF = 40;
  localparam int SCREEN_ROWS_DEF = 24;

  localparam int WIN_W   = 24;
  localparam int BLINK_W = 18;
  localparam logic [BLINK_W-1:0] BLINK_HALF_PERIOD_US = 18'd250000;
  localparam logic [WIN_W-1:0]   ELAPSED_SAT          = 24'hFFFFFF;

  // selector codes
  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_TICK  = 2'd2;

  // character codes
  localparam logic [6:0] CH_CURSOR  = 7'h00;
  localparam logic [6:0] CH_CR      = 7'h0D;
  localparam logic [6:0] CH_SPACE   = 7'h20;
  localparam logic [6:0] CH_AT      = 7'h40;
  localparam logic [6:0] CH_BOX     = 7'h5F;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_LOWER_Z = 7'h7A;
  localparam logic [6:0] CH_TILDE   = 7'h7E;
  localparam logic [6:0] CASE_FOLD  = 7'd32;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [5:0] cell_col;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cell_glyph;
    logic       display_ready;
    logic [4:0] cursor_row_out;
    logic [5:0] cursor_col_out;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic rd_en;
    logic wr_first;
    logic scr_step;
    logic wr_cursor;
    logic clr_step;
    logic load_out;
  } cdt_cmd_t;

  typedef struct packed {
    logic is_write_act;
    logic is_read;
    logic need_scroll;
    logic clr_last;
    logic scr_last;
    logic out_free;
  } cdt_stat_t;

endpackage

// ----- hw/rtl/cdt_ctrl.sv -----
// sequencing state machine for the display terminal
module cdt_ctrl
  import cdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cdt_stat_t stat,
  output cdt_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_DISPATCH = 8'b0000_0100,
    ST_RD       = 8'b0000_1000,
    ST_WR1      = 8'b0001_0000,
    ST_SCROLL   = 8'b0010_0000,
    ST_WR2      = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.exec = 1'b1;
        if (stat.is_write_act) begin
          state_nxt = ST_WR1;
        end else if (stat.is_read) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_WR1: begin
        cmd.wr_first = 1'b1;
        state_nxt = stat.need_scroll ? ST_SCROLL : ST_WR2;
      end
      ST_SCROLL: begin
        cmd.scr_step = 1'b1;
        if (stat.scr_last) begin
          state_nxt = ST_WR2;
        end
      end
      ST_WR2: begin
        cmd.wr_cursor = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DISPATCH))
    else $error("accepted beat not dispatched");

  a_scroll_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL && stat.scr_last) |=> (state_r == ST_WR2))
    else $error("scroll did not end in cursor write");
`endif

endmodule

// ----- hw/rtl/cdt_dp.sv -----
// screen memory, cursor, timers and result register of the display terminal
module cdt_dp
  import cdt_pkg::*;
#(
  parameter int SCREEN_COLS = SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cdt_cmd_t         cmd,
  output cdt_stat_t        stat,
  input  in_item_t         in_data,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_wdata,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int COL_W  = $clog2(SCREEN_COLS);
  localparam int DEPTH  = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W:0]   ROWS_S   = (ROW_W + 1)'(SCREEN_ROWS);
  localparam logic [5:0]       ROWS_LIM = 6'(SCREEN_ROWS);
  localparam logic [6:0]       COLS_LIM = 7'(SCREEN_COLS);

  logic [6:0] mem [DEPTH];
  logic [6:0] rd_data_r;

  in_item_t           item_r;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]   off_r, off_nxt;
  logic [WIN_W-1:0]   elapsed_r, elapsed_nxt;
  logic [BLINK_W-1:0] phase_r, phase_nxt;
  logic               blink_r, blink_nxt;
  logic [WIN_W-1:0]   window_r;
  logic [ROW_W-1:0]   clr_row_r;
  logic [COL_W-1:0]   clr_col_r;
  logic [ROW_W-1:0]   scr_row_r;
  logic [COL_W-1:0]   scr_col_r;
  logic               out_valid_r;
  out_item_t          out_data_r, out_data_nxt;

  // character decode
  logic [6:0] code_v, folded;
  logic       is_cr, is_print, is_lower, wrap_line;

  assign code_v    = item_r.char_code[6:0];
  assign is_cr     = (code_v == CH_CR);
  assign is_print  = (code_v >= CH_SPACE) && (code_v <= CH_TILDE);
  assign is_lower  = (code_v >= CH_LOWER_A) && (code_v <= CH_LOWER_Z);
  assign folded    = is_lower ? (code_v - CASE_FOLD) : code_v;
  assign wrap_line = is_cr || (cur_col_r == COL_LAST);

  assign stat.is_write_act = (item_r.func == FN_WRITE) && (is_cr || is_print);
  assign stat.is_read      = (item_r.func == FN_READ);
  assign stat.need_scroll  = wrap_line && (cur_row_r == ROW_LAST);
  assign stat.clr_last     = (clr_row_r == ROW_LAST) && (clr_col_r == COL_LAST);
  assign stat.scr_last     = (scr_col_r == COL_LAST);
  assign stat.out_free     = !out_valid_r || out_ready;

  // memory address: reads and writes rotate the logical row by the top row offset; clear and scroll use physical rows
  logic [ROW_W-1:0]  log_row, phys_row;
  logic              add_off;
  logic [COL_W-1:0]  acc_col;
  logic [ROW_W:0]    row_sum;
  logic [ADDR_W-1:0] acc_addr;
  logic [6:0]        mem_wdata;
  logic              mem_we;

  always_comb begin
    log_row   = cur_row_r;
    add_off   = 1'b1;
    acc_col   = cur_col_r;
    mem_wdata = CH_CURSOR;
    mem_we    = 1'b0;
    if (cmd.clr_step) begin
      log_row   = clr_row_r;
      add_off   = 1'b0;
      acc_col   = clr_col_r;
      mem_wdata = (clr_row_r[0] ^ clr_col_r[0]) ? CH_BOX : CH_CURSOR;
      mem_we    = 1'b1;
    end else if (cmd.scr_step) begin
      log_row   = scr_row_r;
      add_off   = 1'b0;
      acc_col   = scr_col_r;
      mem_wdata = CH_SPACE;
      mem_we    = 1'b1;
    end else if (cmd.rd_en) begin
      log_row = ROW_W'(item_r.cell_row);
      acc_col = COL_W'(item_r.cell_col);
    end else begin
      mem_wdata = cmd.wr_first ? (is_cr ? CH_SPACE : folded) : CH_CURSOR;
      mem_we    = cmd.wr_first || cmd.wr_cursor;
    end
    row_sum  = {1'b0, log_row} + (add_off ? {1'b0, off_r} : '0);
    phys_row = (row_sum >= ROWS_S) ? ROW_W'(row_sum - ROWS_S) : row_sum[ROW_W-1:0];
    acc_addr = ADDR_W'(ADDR_W'(phys_row) * ADDR_W'(SCREEN_COLS)) + ADDR_W'(acc_col);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[acc_addr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[acc_addr];
    end
  end

  // cursor, scroll, tick and pacing updates
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    off_nxt     = off_r;
    elapsed_nxt = elapsed_r;
    phase_nxt   = phase_r;
    blink_nxt   = blink_r;
    if (cmd.wr_first) begin
      if (wrap_line) begin
        cur_col_nxt = '0;
        if (cur_row_r == ROW_LAST) begin
          off_nxt = (off_r == ROW_LAST) ? '0 : off_r + 1'b1;
        end else begin
          cur_row_nxt = cur_row_r + 1'b1;
        end
      end else begin
        cur_col_nxt = cur_col_r + 1'b1;
      end
    end
    if (cmd.exec) begin
      if (item_r.func == FN_WRITE && window_r != '0) begin
        elapsed_nxt = '0;
      end
      if (item_r.func == FN_TICK) begin
        if (elapsed_r != ELAPSED_SAT) begin
          elapsed_nxt = elapsed_r + 1'b1;
        end
        phase_nxt = phase_r + 1'b1;
        if (phase_nxt >= BLINK_HALF_PERIOD_US) begin
          phase_nxt = '0;
          blink_nxt = !blink_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      off_r     <= '0;
      elapsed_r <= ELAPSED_SAT;
      phase_r   <= '0;
      blink_r   <= 1'b0;
      window_r  <= '0;
      clr_row_r <= '0;
      clr_col_r <= '0;
      scr_col_r <= '0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      off_r     <= off_nxt;
      elapsed_r <= elapsed_nxt;
      phase_r   <= phase_nxt;
      blink_r   <= blink_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      if (cmd.clr_step && !stat.clr_last) begin
        if (clr_col_r == COL_LAST) begin
          clr_col_r <= '0;
          clr_row_r <= clr_row_r + 1'b1;
        end else begin
          clr_col_r <= clr_col_r + 1'b1;
        end
      end
      if (cmd.wr_first) begin
        scr_col_r <= '0;
      end else if (cmd.scr_step) begin
        scr_col_r <= scr_col_r + 1'b1;
      end
    end
  end

  // the row that scrolls into the bottom is the old top row
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.wr_first) begin
      scr_row_r <= off_r;
    end
  end

  // result beat
  logic in_range;

  assign in_range = ({1'b0, item_r.cell_row} < ROWS_LIM) && ({1'b0, item_r.cell_col} < COLS_LIM);

  always_comb begin
    out_data_nxt.cell_glyph = '0;
    if (item_r.func == FN_READ) begin
      if (!in_range) begin
        out_data_nxt.cell_glyph = CH_SPACE;
      end else if (rd_data_r == CH_CURSOR) begin
        out_data_nxt.cell_glyph = blink_r ? CH_AT : CH_SPACE;
      end else begin
        out_data_nxt.cell_glyph = rd_data_r;
      end
    end
    out_data_nxt.display_ready  = (window_r == '0) || (elapsed_r >= window_r);
    out_data_nxt.cursor_row_out = 5'(cur_row_r);
    out_data_nxt.cursor_col_out = 6'(cur_col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r <= ROW_LAST) && (cur_col_r <= COL_LAST) && (off_r <= ROW_LAST))
    else $error("cursor or row offset out of range");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("pending result beat overwritten");

  a_scroll_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_first && stat.need_scroll) |=> (cur_row_r == ROW_LAST) && (cur_col_r == '0))
    else $error("scroll left cursor off bottom row start");
`endif

endmodule

// ----- hw/rtl/character_display_terminal_core.sv -----
// steps: accept, dispatch, then a memory read for a read or the character and cursor writes for a
// write, then the result register; a write that scrolls blanks the new bottom row in between, one
// cell a cycle on the single screen memory port; the next beat is taken the cycle after a result is
// registered, even while it waits at the output; reset is synchronous; afterwards the screen memory
// is loaded cell by cell with the checkerboard while in_ready stays low; config writes are taken
module character_display_terminal_core
  import cdt_pkg::*;
#(
  parameter int SCREEN_COLS = SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_wdata
);

  cdt_cmd_t  cmd;
  cdt_stat_t stat;

  cdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdt_dp #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
